// ===== sv/ipfc_pkg.sv =====
`timescale 1ns / 1ps

package ipfc_pkg;

  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned CfgIdxW     = 4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACTIVE
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_HEAD  = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_TAIL  = 3'd3,
    ST_BAD_CKSUM = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEAD_FLAG = 4'd0,
    REG_TAIL_FLAG = 4'd1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [6:0]  version;
    logic [7:0]  key_byte;
    logic [7:0]  ret_code;
    logic [31:0] sess_num;
    logic [15:0] sequence_res;
    logic [15:0] packet_length;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] reg_idx;
    logic [7:0]         wdata;
  } cfg_t;

  typedef struct packed {
    logic [7:0] head_flag;
    logic [7:0] tail_flag;
  } flags_t;

endpackage

// ===== sv/ipfc_intf.sv =====
`timescale 1ns / 1ps

interface ipfc_in_if;
  import ipfc_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ipfc_out_if;
  import ipfc_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ipfc_cfg_if;
  import ipfc_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ipfc_core.sv =====
`timescale 1ns / 1ps

module ipfc_core #(
  parameter int unsigned HEADER_BYTES = ipfc_pkg::HeaderBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  ipfc_pkg::in_t   item_i,
  input  ipfc_pkg::flags_t flags_i,
  output logic            res_valid_o,
  output ipfc_pkg::out_t  res_o
);
  import ipfc_pkg::*;

  localparam logic [15:0] MinLen     = 16'(HEADER_BYTES + 2);
  localparam logic [15:0] OfsHead    = 16'd0;
  localparam logic [15:0] OfsVersion = 16'd1;
  localparam logic [15:0] OfsKey     = 16'd2;
  localparam logic [15:0] OfsRet     = 16'd3;
  localparam logic [15:0] OfsSess0   = 16'd4;
  localparam logic [15:0] OfsSess1   = 16'd5;
  localparam logic [15:0] OfsSess2   = 16'd6;
  localparam logic [15:0] OfsSess3   = 16'd7;
  localparam logic [15:0] OfsLenLo   = 16'd8;
  localparam logic [15:0] OfsLenHi   = 16'd9;
  localparam logic [15:0] OfsSeqLo   = 16'd10;
  localparam logic [15:0] OfsSeqHi   = 16'd11;

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  cks_q, cks_d;
  logic [6:0]  ver_q, ver_d;
  logic [7:0]  key_q, key_d;
  logic [7:0]  ret_q, ret_d;
  logic [31:0] sess_q, sess_d;
  logic [15:0] seq_q, seq_d;

  logic        active;
  logic [15:0] idx;
  logic [15:0] cur_len;
  logic [7:0]  cur_sum;
  logic [7:0]  cur_cks;
  logic [7:0]  b;
  logic        tail_hit;
  logic        cks_hit;
  status_e     status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
      len_q   <= '0;
      cks_q   <= '0;
      ver_q   <= '0;
      key_q   <= '0;
      ret_q   <= '0;
      sess_q  <= '0;
      seq_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      cks_q   <= cks_d;
      ver_q   <= ver_d;
      key_q   <= key_d;
      ret_q   <= ret_d;
      sess_q  <= sess_d;
      seq_q   <= seq_d;
    end
  end

  always_comb begin
    b       = item_i.data_byte;
    active  = fire_i && (item_i.frame_start || (phase_q == PH_ACTIVE));
    idx     = item_i.frame_start ? '0 : cnt_q;
    cur_len = item_i.frame_start ? '0 : len_q;
    cur_sum = item_i.frame_start ? '0 : sum_q;
    cur_cks = item_i.frame_start ? '0 : cks_q;

    tail_hit = (idx >= OfsSeqLo) && ({1'b0, idx} + 17'd1 == {1'b0, cur_len});
    cks_hit  = (idx >= OfsSeqLo) && ({1'b0, idx} + 17'd2 == {1'b0, cur_len});

    phase_d = phase_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    len_d   = len_q;
    cks_d   = cks_q;
    ver_d   = ver_q;
    key_d   = key_q;
    ret_d   = ret_q;
    sess_d  = sess_q;
    seq_d   = seq_q;

    res_valid_o = 1'b0;
    status      = ST_OK;

    if (active) begin
      phase_d = PH_ACTIVE;
      len_d   = cur_len;
      sum_d   = cur_sum;
      cks_d   = cur_cks;
      cnt_d   = idx + 16'd1;
      if ((idx == OfsHead) && (b != flags_i.head_flag)) begin
        res_valid_o = 1'b1;
        status      = ST_BAD_HEAD;
      end else if (tail_hit) begin
        res_valid_o = 1'b1;
        if (b != flags_i.tail_flag) begin
          status = ST_BAD_TAIL;
        end else if (cur_cks != cur_sum) begin
          status = ST_BAD_CKSUM;
        end else begin
          status = ST_OK;
        end
      end else begin
        if (cks_hit) begin
          cks_d = b;
        end else begin
          sum_d = cur_sum + b;
        end
        case (idx)
          OfsVersion: ver_d = b[6:0];
          OfsKey:     key_d = b;
          OfsRet:     ret_d = b;
          OfsSess0:   sess_d[7:0] = b;
          OfsSess1:   sess_d[15:8] = b;
          OfsSess2:   sess_d[23:16] = b;
          OfsSess3:   sess_d[31:24] = b;
          OfsLenLo:   len_d = {8'd0, b};
          OfsLenHi: begin
            len_d = {b, cur_len[7:0]};
            if ({b, cur_len[7:0]} < MinLen) begin
              res_valid_o = 1'b1;
              status      = ST_BAD_LEN;
            end
          end
          OfsSeqLo:   seq_d[7:0] = b;
          OfsSeqHi:   seq_d[15:8] = b;
          default: ;
        endcase
      end
      if (res_valid_o) begin
        phase_d = PH_IDLE;
      end
    end

    res_o.status        = status;
    res_o.version       = (status == ST_OK) ? ver_q : '0;
    res_o.key_byte      = (status == ST_OK) ? key_q : '0;
    res_o.ret_code      = (status == ST_OK) ? ret_q : '0;
    res_o.sess_num      = (status == ST_OK) ? sess_q : '0;
    res_o.sequence_res  = (status == ST_OK) ? seq_q : '0;
    res_o.packet_length = (status == ST_BAD_HEAD) ? '0 : len_d;
  end

endmodule

// ===== sv/im_packet_frame_checker.sv =====
`timescale 1ns / 1ps

// The checker takes one packet byte per clock cycle unless stalled and reports at most
// one result item per packet, either at the last byte or at the first error, and each
// result is registered. Per-byte work is a single add and compare pass between the packet
// state registers and the result register. A result register backed by a one-entry skid
// stage lets input bytes keep flowing while a result waits; the input stalls only when
// both hold a result. Configuration writes are accepted in every cycle.
module im_packet_frame_checker #(
  parameter int unsigned HEADER_BYTES = ipfc_pkg::HeaderBytes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipfc_in_if.sink   in_i,
  ipfc_out_if.source out_o,
  ipfc_cfg_if.sink  cfg_i
);
  import ipfc_pkg::*;

  flags_t flags_q;
  logic   out_v_q;
  out_t   out_q;
  logic   skid_v_q;
  out_t   skid_q;
  logic   in_fire;
  logic   res_v;
  out_t   res;
  logic   out_load;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !skid_v_q;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_load    = !out_v_q || out_o.ready;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_idx)
        REG_HEAD_FLAG: flags_q.head_flag <= cfg_i.data.wdata;
        REG_TAIL_FLAG: flags_q.tail_flag <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  ipfc_core #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .item_i      (in_i.data),
    .flags_i     (flags_q),
    .res_valid_o (res_v),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_load) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= res_v;
      end
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (res_v) begin
        out_q <= res;
      end
    end else if (res_v) begin
      skid_q <= res;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> out_v_q)
    else $error("skid stage holds a result while the result register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_o.ready))
    else $error("skid stage filled without a stalled result");

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_v |-> in_fire)
    else $error("result produced without an accepted item");

endmodule

// ===== tb/im_packet_frame_checker_tb.sv =====
`timescale 1ns / 1ps

module im_packet_frame_checker_tb;
  import ipfc_pkg::*;

  typedef enum {
    FK_GOOD,
    FK_BAD_HEAD,
    FK_SHORT_LEN,
    FK_BAD_TAIL,
    FK_BAD_SUM,
    FK_BAD_BOTH,
    FK_CUT,
    FK_NOISE
  } frame_kind_e;

  typedef enum {
    FILL_RAND,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  typedef struct {
    frame_kind_e kind;
    logic [15:0] len;
    fill_e       fill;
    logic        typed;
    status_e     st;
    logic [15:0] plen;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  ipfc_in_if  in_if ();
  ipfc_out_if out_if ();
  ipfc_cfg_if cfg_if ();

  im_packet_frame_checker dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Local copy of the checker state, advanced once per accepted byte.
  logic [7:0]  head_q;
  logic [7:0]  tail_q;
  logic        fr_active;
  logic [15:0] fr_count;
  logic [7:0]  fr_sum;
  logic [15:0] fr_len;
  logic [7:0]  fr_cksum;
  logic [6:0]  fr_ver;
  logic [7:0]  fr_key;
  logic [7:0]  fr_ret;
  logic [31:0] fr_session;
  logic [15:0] fr_seq;

  out_t pending_results[$];
  out_t want;
  out_t typed_res;
  logic typed_armed;

  logic gaps_on;
  logic frame_gaps;
  int   stall_left;
  int   errors;
  int   bytes_fed;
  int   frames_fed;
  int   results_seen;
  int   result_tally[8];

  dir_row_t dir_rows [16] = '{
    '{FK_GOOD,      16'd14,    FILL_ZERO, 1'b1, ST_OK,        16'd14},
    '{FK_BAD_HEAD,  16'd14,    FILL_ZERO, 1'b1, ST_BAD_HEAD,  16'd0},
    '{FK_SHORT_LEN, 16'd0,     FILL_ZERO, 1'b1, ST_BAD_LEN,   16'd0},
    '{FK_SHORT_LEN, 16'd13,    FILL_ONES, 1'b1, ST_BAD_LEN,   16'd13},
    '{FK_GOOD,      16'd14,    FILL_ONES, 1'b0, ST_OK,        16'd0},
    '{FK_GOOD,      16'd15,    FILL_RAND, 1'b0, ST_OK,        16'd0},
    '{FK_BAD_TAIL,  16'd20,    FILL_ZERO, 1'b1, ST_BAD_TAIL,  16'd20},
    '{FK_BAD_SUM,   16'd20,    FILL_ZERO, 1'b1, ST_BAD_CKSUM, 16'd20},
    '{FK_BAD_BOTH,  16'd20,    FILL_ZERO, 1'b1, ST_BAD_TAIL,  16'd20},
    '{FK_CUT,       16'd30,    FILL_RAND, 1'b0, ST_OK,        16'd0},
    '{FK_GOOD,      16'd16,    FILL_RAND, 1'b0, ST_OK,        16'd0},
    '{FK_NOISE,     16'd6,     FILL_RAND, 1'b0, ST_OK,        16'd0},
    '{FK_GOOD,      16'd300,   FILL_ONES, 1'b0, ST_OK,        16'd0},
    '{FK_CUT,       16'hFFFF,  FILL_ONES, 1'b0, ST_OK,        16'd0},
    '{FK_BAD_TAIL,  16'd64,    FILL_RAND, 1'b1, ST_BAD_TAIL,  16'd64},
    '{FK_GOOD,      16'd14,    FILL_RAND, 1'b0, ST_OK,        16'd0}
  };

  always #6 clk_i = ~clk_i;

  function automatic out_t close_frame(input status_e st);
    out_t res;
    res = '0;
    res.status = st;
    if (st == ST_OK) begin
      res.version      = fr_ver;
      res.key_byte     = fr_key;
      res.ret_code     = fr_ret;
      res.sess_num     = fr_session;
      res.sequence_res = fr_seq;
    end
    res.packet_length = (st == ST_BAD_HEAD) ? 16'd0 : fr_len;
    fr_active = 1'b0;
    return res;
  endfunction

  function automatic logic frame_step(input logic [7:0] b, input logic st, output out_t res);
    int unsigned idx;
    res = '0;
    if (st) begin
      fr_active  = 1'b1;
      fr_count   = '0;
      fr_sum     = '0;
      fr_len     = '0;
      fr_cksum   = '0;
      fr_ver     = '0;
      fr_key     = '0;
      fr_ret     = '0;
      fr_session = '0;
      fr_seq     = '0;
    end else if (!fr_active) begin
      return 1'b0;
    end
    idx = fr_count;
    if (idx == 0 && b != head_q) begin
      res = close_frame(ST_BAD_HEAD);
      return 1'b1;
    end
    if (idx >= 10 && idx + 1 == fr_len) begin
      if (b != tail_q) begin
        res = close_frame(ST_BAD_TAIL);
      end else if (fr_cksum != fr_sum) begin
        res = close_frame(ST_BAD_CKSUM);
      end else begin
        res = close_frame(ST_OK);
      end
      return 1'b1;
    end
    if (idx >= 10 && idx + 2 == fr_len) begin
      fr_cksum = b;
    end else begin
      fr_sum = fr_sum + b;
    end
    case (idx)
      1: fr_ver = b[6:0];
      2: fr_key = b;
      3: fr_ret = b;
      4: fr_session[7:0] = b;
      5: fr_session[15:8] = b;
      6: fr_session[23:16] = b;
      7: fr_session[31:24] = b;
      8: fr_len = {8'd0, b};
      9: begin
        fr_len[15:8] = b;
        if (fr_len < HeaderBytes + 2) begin
          res = close_frame(ST_BAD_LEN);
          return 1'b1;
        end
      end
      10: fr_seq[7:0] = b;
      11: fr_seq[15:8] = b;
      default: ;
    endcase
    fr_count = fr_count + 16'd1;
    return 1'b0;
  endfunction

  function automatic void build_frame(input frame_kind_e kind, input logic [15:0] len,
                                      input fill_e fill, output logic [7:0] frame[$]);
    int n;
    logic [7:0] sum;
    case (kind)
      FK_SHORT_LEN: n = 12 + $urandom_range(0, 4);
      FK_CUT: n = $urandom_range(1, (len > 40) ? 40 : len - 1);
      default: n = len;
    endcase
    frame = {};
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_ZERO: frame.push_back(8'h00);
        FILL_ONES: frame.push_back(8'hFF);
        default: frame.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (kind == FK_NOISE) begin
      return;
    end
    frame[0] = head_q;
    if (kind == FK_BAD_HEAD) begin
      frame[0] = head_q ^ 8'($urandom_range(1, 255));
    end
    if (n > 9) begin
      frame[8] = len[7:0];
      frame[9] = len[15:8];
    end
    if (kind inside {FK_GOOD, FK_BAD_TAIL, FK_BAD_SUM, FK_BAD_BOTH}) begin
      sum = '0;
      for (int i = 0; i < len - 2; i++) begin
        sum = sum + frame[i];
      end
      frame[len-2] = sum;
      frame[len-1] = tail_q;
      if (kind inside {FK_BAD_SUM, FK_BAD_BOTH}) begin
        frame[len-2] = sum ^ 8'($urandom_range(1, 255));
      end
      if (kind inside {FK_BAD_TAIL, FK_BAD_BOTH}) begin
        frame[len-1] = tail_q ^ 8'($urandom_range(1, 255));
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, exp_val);
    errors++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st);
    out_t res;
    logic got;
    if (gaps_on && frame_gaps && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{data_byte: b, frame_start: st};
    do @(posedge clk_i); while (!in_if.ready);
    got = frame_step(b, st, res);
    if (got) begin
      if (typed_armed) begin
        res = typed_res;
        typed_armed = 1'b0;
      end
      pending_results.push_back(res);
    end
  endtask

  task automatic send_frame(input frame_kind_e kind, input logic [15:0] len, input fill_e fill,
                            input logic mangle);
    logic [7:0] frame[$];
    logic [7:0] b;
    logic st;
    build_frame(kind, len, fill, frame);
    frame_gaps = ($urandom_range(0, 3) != 0);
    foreach (frame[i]) begin
      b  = frame[i];
      st = (i == 0 && kind != FK_NOISE);
      if (mangle && $urandom_range(0, 199) == 0) begin
        b = b ^ 8'($urandom_range(1, 255));
      end
      if (mangle && i > 0 && $urandom_range(0, 299) == 0) begin
        st = 1'b1;
      end
      send_byte(b, st);
      if (kind != FK_NOISE) begin
        bytes_fed++;
      end
    end
    frames_fed++;
  endtask

  // The last byte of a frame can still be in flight with no result due, so the task
  // keeps waiting for a while after the queue is empty.
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_flags(input logic [7:0] h, input logic [7:0] t);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{reg_idx: REG_HEAD_FLAG, wdata: h};
    do @(posedge clk_i); while (!cfg_if.ready);
    head_q = h;
    cfg_if.data <= '{reg_idx: REG_TAIL_FLAG, wdata: t};
    do @(posedge clk_i); while (!cfg_if.ready);
    tail_q = t;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FK_GOOD;
    if (r < 62) return FK_BAD_HEAD;
    if (r < 68) return FK_SHORT_LEN;
    if (r < 75) return FK_BAD_TAIL;
    if (r < 82) return FK_BAD_SUM;
    if (r < 86) return FK_BAD_BOTH;
    if (r < 93) return FK_CUT;
    return FK_NOISE;
  endfunction

  function automatic logic [15:0] pick_len(input frame_kind_e kind);
    int r;
    r = $urandom_range(0, 99);
    if (kind == FK_SHORT_LEN) return 16'($urandom_range(0, 13));
    if (kind == FK_NOISE) return 16'($urandom_range(1, 8));
    if (kind == FK_CUT && r < 10) return 16'($urandom_range(14, 65535));
    if (r < 80) return 16'($urandom_range(14, 40));
    if (r < 97) return 16'($urandom_range(41, 200));
    return 16'($urandom_range(201, 600));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      result_tally[int'(out_if.data.status)]++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_if.data.status), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.data.status !== want.status)
          report_mismatch("status", 32'(out_if.data.status), 32'(want.status));
        if (out_if.data.version !== want.version)
          report_mismatch("version", 32'(out_if.data.version), 32'(want.version));
        if (out_if.data.key_byte !== want.key_byte)
          report_mismatch("key_byte", 32'(out_if.data.key_byte), 32'(want.key_byte));
        if (out_if.data.ret_code !== want.ret_code)
          report_mismatch("ret_code", 32'(out_if.data.ret_code), 32'(want.ret_code));
        if (out_if.data.sess_num !== want.sess_num)
          report_mismatch("sess_num", out_if.data.sess_num, want.sess_num);
        if (out_if.data.sequence_res !== want.sequence_res)
          report_mismatch("sequence_res", 32'(out_if.data.sequence_res),
                          32'(want.sequence_res));
        if (out_if.data.packet_length !== want.packet_length)
          report_mismatch("packet_length", 32'(out_if.data.packet_length),
                          32'(want.packet_length));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    #20_000_000;
    $display("[im_packet_frame_checker] ERROR");
    $finish;
  end

  initial begin
    logic [7:0] phase_head [4];
    logic [7:0] phase_tail [4];
    frame_kind_e kind;
    fill_e fill;
    int mark;
    int r;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    head_q       = '0;
    tail_q       = '0;
    fr_active    = 1'b0;
    fr_count     = '0;
    typed_armed  = 1'b0;
    typed_res    = '0;
    gaps_on      = 1'b1;
    frame_gaps   = 1'b1;
    stall_left   = 0;
    errors       = 0;
    bytes_fed    = 0;
    frames_fed   = 0;
    results_seen = 0;
    foreach (result_tally[i]) result_tally[i] = 0;
    phase_head = '{8'hFF, 8'h00, 8'hFF, 8'($urandom_range(0, 255))};
    phase_tail = '{8'hFF, 8'hFF, 8'h00, 8'($urandom_range(0, 255))};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      typed_res               = '0;
      typed_res.status        = dir_rows[i].st;
      typed_res.packet_length = dir_rows[i].plen;
      typed_armed             = dir_rows[i].typed;
      send_frame(dir_rows[i].kind, dir_rows[i].len, dir_rows[i].fill, 1'b0);
    end
    typed_armed = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      wait_quiet();
      set_flags(phase_head[ph], phase_tail[ph]);
      if (ph == 3) begin
        gaps_on = 1'b0;
      end
      mark = bytes_fed;
      while (bytes_fed - mark < 340) begin
        kind = pick_kind();
        r = $urandom_range(0, 19);
        fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RAND;
        send_frame(kind, pick_len(kind), fill, 1'b1);
      end
    end

    wait_quiet();
    $display("Fed %0d frames (%0d packet bytes) across five flag settings; %0d results checked.",
             frames_fed, bytes_fed, results_seen);
    $display("Status mix: ok %0d, head %0d, length %0d, tail %0d, checksum %0d.",
             result_tally[0], result_tally[1], result_tally[2], result_tally[3],
             result_tally[4]);
    if (errors == 0) begin
      $display("[im_packet_frame_checker] OK");
    end else begin
      $display("[im_packet_frame_checker] ERROR");
    end
    $finish;
  end

endmodule
